/* rtl/tet_pkg.sv */
// ----------------------------------------------------------------------------
// tet_pkg
// Shared types and constants of the timeline event trigger.
// ----------------------------------------------------------------------------
package tet_pkg;

    // Field widths
    localparam int TIME_W    = 32;
    localparam int ID_W      = 6;
    localparam int IDX_W     = 5;
    localparam int CUR_W     = 7;
    localparam int NUM_W     = 6;
    localparam int MASK_W    = 64;
    localparam int CFG_IDX_W = 1;

    // Stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 56;

    // Fire limit per evaluate and its counter width
    localparam int FIRE_CAP = 32;
    localparam int FIRE_W   = 6;

    // Item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_EVENTS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HANDLER_MASK = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BACK,
        ST_FWD,
        ST_REPOS,
        ST_WRAP,
        ST_CATCH,
        ST_STATUS
    } t_state;

    // One result item handed from the sequencer to the output register
    typedef struct packed {
        logic              valid;
        logic              fired;
        logic [ID_W-1:0]   event_id;
        logic [IDX_W-1:0]  index;
        logic [TIME_W-1:0] fire_time;
        logic [CUR_W-1:0]  cursor;
        logic              last;
    } t_result;

endpackage

/* rtl/tet_ram.sv */
// ----------------------------------------------------------------------------
// tet_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tet_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry into the output register
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/tet_scan.sv */
// ----------------------------------------------------------------------------
// tet_scan
// Cursor sequencer: writes loaded entries, produces fire and status items,
// and walks the table via the RAM read port one slot a cycle unless stalled.
// ----------------------------------------------------------------------------
module tet_scan #(
    parameter int MAX_EVENTS = 32,
    localparam int AW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1,
    localparam int IW = $clog2(MAX_EVENTS + 2) + 1,
    localparam int DW = tet_pkg::TIME_W + tet_pkg::ID_W
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input item
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_kind,
    input  logic [tet_pkg::IDX_W-1:0]      i_entry_index,
    input  logic [tet_pkg::TIME_W-1:0]     i_entry_time,
    input  logic [tet_pkg::ID_W-1:0]       i_entry_event_id,
    input  logic [tet_pkg::TIME_W-1:0]     i_prev_time,
    input  logic [tet_pkg::TIME_W-1:0]     i_cur_time,
    // configuration
    input  logic [tet_pkg::NUM_W-1:0]      i_num_events,
    input  logic [tet_pkg::MASK_W-1:0]     i_handler_mask,
    // result towards the output register
    input  logic                           i_out_busy,
    output tet_pkg::t_result               o_result,
    // table RAM
    output logic                           o_ram_we,
    output logic [AW-1:0]                  o_ram_waddr,
    output logic [DW-1:0]                  o_ram_wdata,
    output logic [AW-1:0]                  o_ram_raddr,
    input  logic [DW-1:0]                  i_ram_rdata
);

    localparam logic signed [IW-1:0] MAXI = IW'(MAX_EVENTS);
    localparam logic signed [IW-1:0] ONE  = IW'(1);
    localparam logic signed [IW-1:0] ZERO = '0;

    tet_pkg::t_state r_state, n_state;

    logic signed [IW-1:0]          r_i, n_i;
    logic signed [IW-1:0]          r_cursor, n_cursor;
    logic                          r_oob;
    logic [tet_pkg::TIME_W-1:0]    r_prev, r_cur, r_cached;
    logic [tet_pkg::FIRE_W-1:0]    r_fires;

    logic                          accept, eval_acc;
    logic signed [IW-1:0]          num_s, ncnt;
    logic [tet_pkg::TIME_W-1:0]    slot_time;
    logic [tet_pkg::ID_W-1:0]      slot_id;
    logic                          lt_n, nxt_lt_n, at_zero;
    logic                          c_back, c_fwd, c_rep, c_catch;
    logic                          hit, emit_fire, emit_status, n_oob;
    logic                          back_start;

    // Slot data; slots outside the table read as zero
    assign slot_time = r_oob ? '0 : i_ram_rdata[tet_pkg::TIME_W-1:0];
    assign slot_id   = r_oob ? '0 : i_ram_rdata[DW-1:tet_pkg::TIME_W];

    // Active table length
    assign num_s = IW'(i_num_events);
    assign ncnt  = (int'(i_num_events) > MAX_EVENTS) ? MAXI : num_s;

    // Scan conditions on the slot now on the read port
    assign lt_n     = r_i < ncnt;
    assign nxt_lt_n = (r_i + ONE) < ncnt;
    assign at_zero  = r_i == ZERO;
    assign c_back   = r_prev < slot_time;
    assign c_fwd    = lt_n && (slot_time <= r_prev);
    assign c_rep    = r_cur <= slot_time;
    assign c_catch  = lt_n && (slot_time <= r_cur);
    assign hit      = i_handler_mask[slot_id]
                      && (r_fires < tet_pkg::FIRE_W'(tet_pkg::FIRE_CAP));

    assign accept     = i_in_valid && o_in_ready;
    assign eval_acc   = accept && (i_kind == tet_pkg::KIND_EVAL);
    assign back_start = (i_prev_time < r_cached) && (r_cursor >= ZERO);

    assign emit_fire   = !i_out_busy && hit
                         && ((r_state == tet_pkg::ST_WRAP)
                             || ((r_state == tet_pkg::ST_CATCH) && c_catch));
    assign emit_status = !i_out_busy && (r_state == tet_pkg::ST_STATUS);

    assign o_in_ready = r_state == tet_pkg::ST_IDLE;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tet_pkg::ST_IDLE: begin
                if (eval_acc) begin
                    n_state = back_start ? tet_pkg::ST_BACK : tet_pkg::ST_FWD;
                end
            end
            tet_pkg::ST_BACK: begin
                if (!c_back || at_zero) begin
                    n_state = tet_pkg::ST_FWD;
                end
            end
            tet_pkg::ST_FWD: begin
                if (!c_fwd) begin
                    if (r_prev == r_cur) begin
                        n_state = (lt_n || ncnt != ZERO) ? tet_pkg::ST_REPOS
                                                        : tet_pkg::ST_STATUS;
                    end else if (r_prev > r_cur && lt_n) begin
                        n_state = tet_pkg::ST_WRAP;
                    end else begin
                        n_state = tet_pkg::ST_CATCH;
                    end
                end
            end
            tet_pkg::ST_REPOS: begin
                if (!c_rep || at_zero) begin
                    n_state = tet_pkg::ST_STATUS;
                end
            end
            tet_pkg::ST_WRAP: begin
                if (!(hit && i_out_busy) && !nxt_lt_n) begin
                    n_state = tet_pkg::ST_CATCH;
                end
            end
            tet_pkg::ST_CATCH: begin
                if (!c_catch) begin
                    n_state = tet_pkg::ST_STATUS;
                end
            end
            tet_pkg::ST_STATUS: begin
                if (!i_out_busy) begin
                    n_state = tet_pkg::ST_IDLE;
                end
            end
            default: n_state = tet_pkg::ST_IDLE;
        endcase
    end

    // Slot index and cursor
    always_comb begin
        n_i      = r_i;
        n_cursor = r_cursor;
        case (r_state)
            tet_pkg::ST_IDLE: begin
                if (eval_acc) begin
                    n_i = (back_start || r_cursor >= ZERO) ? r_cursor : ZERO;
                end
            end
            tet_pkg::ST_BACK: begin
                if (c_back) begin
                    n_i = at_zero ? ZERO : r_i - ONE;
                end else begin
                    n_i = r_i + ONE;
                end
            end
            tet_pkg::ST_FWD: begin
                if (c_fwd) begin
                    n_i = r_i + ONE;
                end else if (r_prev == r_cur) begin
                    n_i = lt_n ? r_i : ncnt - ONE;
                    if (!lt_n && ncnt == ZERO) begin
                        n_cursor = ZERO;
                    end
                end else if (r_prev > r_cur) begin
                    n_i = lt_n ? r_i : ZERO;
                end
            end
            tet_pkg::ST_REPOS: begin
                if (c_rep) begin
                    n_i = r_i - ONE;
                    if (at_zero) begin
                        n_cursor = ZERO;
                    end
                end else begin
                    n_cursor = r_i + ONE;
                end
            end
            tet_pkg::ST_WRAP: begin
                if (!(hit && i_out_busy)) begin
                    n_i = nxt_lt_n ? r_i + ONE : ZERO;
                end
            end
            tet_pkg::ST_CATCH: begin
                if (c_catch) begin
                    if (!(hit && i_out_busy)) begin
                        n_i = r_i + ONE;
                    end
                end else begin
                    n_cursor = lt_n ? r_i : ncnt - ONE;
                end
            end
            default: ;
        endcase
    end

    // Read the slot of the next index
    assign n_oob       = (n_i < ZERO) || (n_i >= MAXI);
    assign o_ram_raddr = n_oob ? '0 : AW'(n_i);

    // Write loaded entries that fall inside the table
    assign o_ram_we    = accept && (i_kind == tet_pkg::KIND_LOAD)
                         && (int'(i_entry_index) < MAX_EVENTS);
    assign o_ram_waddr = AW'(i_entry_index);
    assign o_ram_wdata = {i_entry_event_id, i_entry_time};

    // Result item
    always_comb begin
        o_result           = '0;
        o_result.valid     = emit_fire || emit_status;
        if (emit_status) begin
            o_result.cursor = tet_pkg::CUR_W'(r_cursor);
            o_result.last   = 1'b1;
        end else begin
            o_result.fired     = 1'b1;
            o_result.event_id  = slot_id;
            o_result.index     = tet_pkg::IDX_W'(r_i);
            o_result.fire_time = r_cur;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tet_pkg::ST_IDLE;
            r_cursor <= '0;
            r_cached <= '0;
            r_fires  <= '0;
            r_i      <= '0;
            r_oob    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cursor <= n_cursor;
            r_i      <= n_i;
            r_oob    <= n_oob;
            if (eval_acc) begin
                r_fires <= '0;
            end else if (emit_fire) begin
                r_fires <= r_fires + 1'b1;
            end
            if (emit_status) begin
                r_cached <= r_cur;
            end
        end
    end

    // Hold the times of the evaluate in progress
    always_ff @(posedge i_clk) begin
        if (eval_acc) begin
            r_prev <= i_prev_time;
            r_cur  <= i_cur_time;
        end
    end

endmodule

/* rtl/timeline_event_trigger_top.sv */
// ----------------------------------------------------------------------------
// timeline_event_trigger_top
// Sorted event table with a cursor: fires events whose trigger time falls
// in each evaluated time step, with wrap handling.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                      Carries
//  s_axis   in         s_axis_tvalid/s_axis_tready    load or evaluate item
//  m_axis   out        m_axis_tvalid/m_axis_tready    fire items, status item
//  cfg      in         i_cfg_valid/o_cfg_ready        register index, data
//
//  A load item writes one table entry. An evaluate walks the table one
//  slot a cycle through the RAM read port: backward steps, forward steps,
//  then reposition or fire steps, and last the status step.
//  A stalled output holds the walk on a slot that fires and on the status
//  step; slots that do not fire go on while one item waits in the register.
//  Reset is synchronous, active low, and clears cursor and cached time;
//  table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module timeline_event_trigger_top #(
    parameter int MAX_EVENTS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input items
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [4:0] entry_index, [36:5] entry_time, [42:37] entry_event_id,
    // [74:43] prev_time, [106:75] cur_time, [111:107] zero
    input  logic [tet_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // [0] kind
    input  logic                               s_axis_tuser,
    // result items
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [5:0] fired_event_id, [10:6] fired_index, [42:11] fire_time,
    // [49:43] cursor_out, [55:50] zero
    output logic [tet_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // [0] event_fired
    output logic                               m_axis_tuser,
    output logic                               m_axis_tlast,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tet_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tet_pkg::MASK_W-1:0]         i_cfg_data
);

    localparam int AW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
    localparam int DW = tet_pkg::TIME_W + tet_pkg::ID_W;

    logic [tet_pkg::NUM_W-1:0]  r_num_events;
    logic [tet_pkg::MASK_W-1:0] r_handler_mask;

    tet_pkg::t_result           result;
    tet_pkg::t_result           r_out;
    logic                       out_busy;

    logic                       ram_we;
    logic [AW-1:0]              ram_waddr, ram_raddr;
    logic [DW-1:0]              ram_wdata, ram_rdata;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_events   <= '0;
            r_handler_mask <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tet_pkg::CFG_NUM_EVENTS:
                    r_num_events <= i_cfg_data[tet_pkg::NUM_W-1:0];
                tet_pkg::CFG_HANDLER_MASK:
                    r_handler_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Event table
    tet_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_EVENTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Cursor sequencer
    tet_scan #(
        .MAX_EVENTS (MAX_EVENTS)
    ) u_scan (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (s_axis_tvalid),
        .o_in_ready       (s_axis_tready),
        .i_kind           (s_axis_tuser),
        .i_entry_index    (s_axis_tdata[4:0]),
        .i_entry_time     (s_axis_tdata[36:5]),
        .i_entry_event_id (s_axis_tdata[42:37]),
        .i_prev_time      (s_axis_tdata[74:43]),
        .i_cur_time       (s_axis_tdata[106:75]),
        .i_num_events     (r_num_events),
        .i_handler_mask   (r_handler_mask),
        .i_out_busy       (out_busy),
        .o_result         (result),
        .o_ram_we         (ram_we),
        .o_ram_waddr      (ram_waddr),
        .o_ram_wdata      (ram_wdata),
        .o_ram_raddr      (ram_raddr),
        .i_ram_rdata      (ram_rdata)
    );

    // Output register: hold an item until taken, load a new one when free
    assign out_busy = r_out.valid && !m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= '0;
        end else if (!out_busy) begin
            r_out <= result;
        end
    end

    assign m_axis_tvalid = r_out.valid;
    assign m_axis_tuser  = r_out.fired;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {6'b0, r_out.cursor, r_out.fire_time,
                            r_out.index, r_out.event_id};

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the timeline event trigger. A scoreboard object
// tracks the event table, cursor, cached time and registers, predicts the
// fire and status items for every accepted evaluate, and checks each result
// item in order. Plain tasks load the table, evaluate time steps and write
// the registers, with random idling on both streams and a long output stall.
// ----------------------------------------------------------------------------
module tb;

    localparam int MAX_EV       = 32;
    localparam int DRAIN_CYCLES = 3 * MAX_EV + 24;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        logic                       fired;
        logic [tet_pkg::ID_W-1:0]   event_id;
        logic [tet_pkg::IDX_W-1:0]  index;
        logic [tet_pkg::TIME_W-1:0] fire_time;
        logic [tet_pkg::CUR_W-1:0]  cursor;
        logic                       last;
    } t_trig_result;

    // ------------------------------------------------------------------------
    // Scoreboard: predicted table walk and queue of expected result items
    // ------------------------------------------------------------------------
    class trigger_scoreboard;
        logic [tet_pkg::TIME_W-1:0] slot_times [MAX_EV];
        logic [tet_pkg::ID_W-1:0]   slot_ids   [MAX_EV];
        int                         cursor;
        logic [tet_pkg::TIME_W-1:0] cached_time;
        logic [tet_pkg::NUM_W-1:0]  num_events;
        logic [tet_pkg::MASK_W-1:0] handler_mask;
        int                         fire_count;
        int                         mismatches;
        t_trig_result               expected_results [$];

        function new();
            for (int k = 0; k < MAX_EV; k++) begin
                slot_times[k] = '0;
                slot_ids[k]   = '0;
            end
            cursor       = 0;
            cached_time  = '0;
            num_events   = '0;
            handler_mask = '0;
            mismatches   = 0;
        endfunction

        // Slots outside the table read as time 0, id 0
        function logic [tet_pkg::TIME_W-1:0] time_at(int i);
            if (i < 0 || i >= MAX_EV)
                return '0;
            return slot_times[i];
        endfunction

        function logic [tet_pkg::ID_W-1:0] id_at(int i);
            if (i < 0 || i >= MAX_EV)
                return '0;
            return slot_ids[i];
        endfunction

        function void push_result(logic fired, logic [tet_pkg::ID_W-1:0] id,
                                  logic [tet_pkg::IDX_W-1:0] idx,
                                  logic [tet_pkg::TIME_W-1:0] t,
                                  logic [tet_pkg::CUR_W-1:0] cur, logic last);
            t_trig_result r;
            r.fired     = fired;
            r.event_id  = id;
            r.index     = idx;
            r.fire_time = t;
            r.cursor    = cur;
            r.last      = last;
            expected_results.push_back(r);
        endfunction

        // Fire only with a handler, and no more than the cap per evaluate
        function void fire_slot(int i, logic [tet_pkg::TIME_W-1:0] now);
            logic [tet_pkg::ID_W-1:0] id;
            id = id_at(i);
            if (!handler_mask[id])
                return;
            if (fire_count >= tet_pkg::FIRE_CAP)
                return;
            fire_count++;
            push_result(1'b1, id, tet_pkg::IDX_W'(i), now, '0, 1'b0);
        endfunction

        function void walk_timeline(logic [tet_pkg::TIME_W-1:0] prev,
                                    logic [tet_pkg::TIME_W-1:0] cur);
            int  n;
            int  i;
            bit  in_table;
            n = (num_events > MAX_EV) ? MAX_EV : int'(num_events);
            fire_count = 0;

            // Step back when time went backward since the cached time
            if (prev < cached_time) begin
                i = cursor;
                while (i > -1 && prev < time_at(i))
                    i--;
                cursor = i + 1;
            end

            // Step forward past events at or before the previous time
            i = cursor;
            if (i < 0)
                i = 0;
            while (i < n && time_at(i) <= prev)
                i++;
            in_table = (i < n);
            cursor = i;

            if (prev == cur) begin
                // Reposition only
                if (!in_table)
                    i = n - 1;
                while (i > -1 && cur <= time_at(i))
                    i--;
                cursor = i + 1;
            end else begin
                // Wrap: fire the tail without a time check, restart at slot 0
                if (prev > cur) begin
                    if (in_table)
                        for (int j = i; j < n; j++)
                            fire_slot(j, cur);
                    cursor = 0;
                end
                i = cursor;
                while (i < n && time_at(i) <= cur) begin
                    fire_slot(i, cur);
                    i++;
                end
                cursor = (i < n) ? i : n - 1;
            end

            cached_time = cur;
            push_result(1'b0, '0, '0, '0, tet_pkg::CUR_W'(cursor), 1'b1);
        endfunction

        function void note_reg_write(logic [tet_pkg::CFG_IDX_W-1:0] index,
                                     logic [tet_pkg::MASK_W-1:0] data);
            if (index == tet_pkg::CFG_NUM_EVENTS)
                num_events = data[tet_pkg::NUM_W-1:0];
            else if (index == tet_pkg::CFG_HANDLER_MASK)
                handler_mask = data;
        endfunction

        function void note_item(logic kind, logic [tet_pkg::IDX_W-1:0] idx,
                                logic [tet_pkg::TIME_W-1:0] etime,
                                logic [tet_pkg::ID_W-1:0] eid,
                                logic [tet_pkg::TIME_W-1:0] prev,
                                logic [tet_pkg::TIME_W-1:0] cur);
            if (kind == tet_pkg::KIND_LOAD) begin
                if (int'(idx) < MAX_EV) begin
                    slot_times[idx] = etime;
                    slot_ids[idx]   = eid;
                end
            end else begin
                walk_timeline(prev, cur);
            end
        endfunction

        function void check_result(t_trig_result got);
            t_trig_result want;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result item: fired=%0b id=%0d idx=%0d %s",
                             got.fired, got.event_id, got.index,
                             $sformatf("t=%h cur=%h last=%0b",
                                       got.fire_time, got.cursor, got.last));
                return;
            end
            want = expected_results.pop_front();
            if (got.fired !== want.fired || got.event_id !== want.event_id ||
                got.index !== want.index || got.fire_time !== want.fire_time ||
                got.cursor !== want.cursor || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("mismatch: exp fired=%0b id=%0d idx=%0d t=%h cur=%h last=%0b",
                             want.fired, want.event_id, want.index, want.fire_time,
                             want.cursor, want.last);
                    $display("          got fired=%0b id=%0d idx=%0d t=%h cur=%h last=%0b",
                             got.fired, got.event_id, got.index, got.fire_time,
                             got.cursor, got.last);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [tet_pkg::S_TDATA_W-1:0]   s_axis_tdata;
    logic                            s_axis_tuser;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [tet_pkg::M_TDATA_W-1:0]   m_axis_tdata;
    logic                            m_axis_tuser;
    logic                            m_axis_tlast;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [tet_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [tet_pkg::MASK_W-1:0]      i_cfg_data;

    trigger_scoreboard               sb = new();
    t_trig_result                    seen_result;
    logic [tet_pkg::TIME_W-1:0]      stim_times [MAX_EV];
    logic [tet_pkg::TIME_W-1:0]      now_time = '0;
    bit                              tx_calm = 1'b0;
    bit                              rx_calm = 1'b0;
    bit                              hold_start = 1'b0;
    bit                              rx_hold = 1'b0;
    int                              stalled_cycles = 0;

    timeline_event_trigger_top #(.MAX_EVENTS(MAX_EV)) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // Clock
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------------
    // Monitor: check results, then note register writes and input items
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen_result.fired     = m_axis_tuser;
                seen_result.event_id  = m_axis_tdata[5:0];
                seen_result.index     = m_axis_tdata[10:6];
                seen_result.fire_time = m_axis_tdata[42:11];
                seen_result.cursor    = m_axis_tdata[49:43];
                seen_result.last      = m_axis_tlast;
                sb.check_result(seen_result);
            end
            if (i_cfg_valid && o_cfg_ready)
                sb.note_reg_write(i_cfg_index, i_cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_item(s_axis_tuser, s_axis_tdata[4:0], s_axis_tdata[36:5],
                             s_axis_tdata[42:37], s_axis_tdata[74:43],
                             s_axis_tdata[106:75]);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
            if (stalled_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("FAIL timeline_event_trigger_top");
                $finish;
            end
        end
    end

    // Long output stall, counted here once triggered
    initial begin
        wait (hold_start);
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold = 1'b0;
    end

    // Receiver: random wait before each result item
    initial begin
        int gap;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = rx_calm ? 0 : $urandom_range(0, 10);
            if (gap != 0 || rx_hold) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                while (rx_hold)
                    @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------
    task automatic send_item(input logic kind, input logic [tet_pkg::IDX_W-1:0] idx,
                             input logic [tet_pkg::TIME_W-1:0] etime,
                             input logic [tet_pkg::ID_W-1:0] eid,
                             input logic [tet_pkg::TIME_W-1:0] prev,
                             input logic [tet_pkg::TIME_W-1:0] cur);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {5'b0, cur, prev, eid, etime, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        if (kind == tet_pkg::KIND_LOAD)
            stim_times[idx] = etime;
    endtask

    // Unused fields carry random junk
    task automatic send_load(input logic [tet_pkg::IDX_W-1:0] idx,
                             input logic [tet_pkg::TIME_W-1:0] etime,
                             input logic [tet_pkg::ID_W-1:0] eid);
        send_item(tet_pkg::KIND_LOAD, idx, etime, eid, $urandom, $urandom);
    endtask

    task automatic send_eval(input logic [tet_pkg::TIME_W-1:0] prev,
                             input logic [tet_pkg::TIME_W-1:0] cur);
        send_item(tet_pkg::KIND_EVAL, tet_pkg::IDX_W'($urandom), $urandom,
                  tet_pkg::ID_W'($urandom), prev, cur);
        now_time = cur;
    endtask

    // Drop the input and hold until every expected item has come
    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_results.size() != 0);
    endtask

    task automatic write_reg(input logic [tet_pkg::CFG_IDX_W-1:0] index,
                             input logic [tet_pkg::MASK_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Registers change only once the walk has drained
    task automatic set_config(input logic [tet_pkg::NUM_W-1:0] n,
                              input logic [tet_pkg::MASK_W-1:0] mask);
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(tet_pkg::CFG_NUM_EVENTS, {$urandom, 26'($urandom_range(0, 3)), n});
        write_reg(tet_pkg::CFG_HANDLER_MASK, mask);
        i_cfg_valid <= 1'b0;
    endtask

    // Load every slot in ascending time order, duplicates allowed
    task automatic fill_table();
        logic [tet_pkg::TIME_W-1:0] t;
        t = $urandom_range(0, 32'hF000_0000);
        for (int k = 0; k < MAX_EV; k++) begin
            send_load(tet_pkg::IDX_W'(k), t, tet_pkg::ID_W'($urandom));
            t = t + tet_pkg::TIME_W'($urandom_range(0, 32'h0003_0000));
        end
    endtask

    // Mostly near a table time, sometimes anywhere
    function automatic logic [tet_pkg::TIME_W-1:0] pick_time();
        logic [tet_pkg::TIME_W-1:0] t;
        if ($urandom_range(0, 9) < 7) begin
            t = stim_times[$urandom_range(0, MAX_EV - 1)];
            t = t + tet_pkg::TIME_W'($urandom_range(0, 4)) - tet_pkg::TIME_W'(2);
        end else begin
            t = $urandom;
        end
        return t;
    endfunction

    task automatic random_items(input int count);
        int unsigned                sel;
        int                         k;
        logic [tet_pkg::TIME_W-1:0] p;
        logic [tet_pkg::TIME_W-1:0] c;
        logic [tet_pkg::TIME_W-1:0] lo;
        logic [tet_pkg::TIME_W-1:0] hi;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 15) begin
                // Reload a slot: mostly keeping order, sometimes breaking it
                k = $urandom_range(0, MAX_EV - 1);
                if (sel < 11) begin
                    lo = (k == 0) ? '0 : stim_times[k-1];
                    hi = (k == MAX_EV - 1) ? '1 : stim_times[k+1];
                    c  = (hi >= lo) ? lo + tet_pkg::TIME_W'($urandom_range(0, hi - lo))
                                    : lo;
                end else begin
                    c = $urandom;
                end
                send_load(tet_pkg::IDX_W'(k), c, tet_pkg::ID_W'($urandom));
            end else begin
                case ($urandom_range(0, 9))
                    0: begin
                        p = pick_time();
                        c = p;
                    end
                    1: begin
                        lo = pick_time();
                        hi = pick_time();
                        p  = (lo > hi) ? lo : hi;
                        c  = (lo > hi) ? hi : lo;
                        if (p == c)
                            p = c + tet_pkg::TIME_W'(1);
                    end
                    2: begin
                        p = $urandom;
                        c = $urandom;
                    end
                    3: begin
                        p = now_time - tet_pkg::TIME_W'($urandom_range(0, 32'h0004_0000));
                        c = p + tet_pkg::TIME_W'($urandom_range(0, 32'h0004_0000));
                    end
                    default: begin
                        p = now_time;
                        c = pick_time();
                        if (c < p)
                            c = p + tet_pkg::TIME_W'($urandom_range(1, 32'h0004_0000));
                    end
                endcase
                send_eval(p, c);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        for (int k = 0; k < MAX_EV; k++)
            stim_times[k] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Full table, every id with a handler
        set_config(tet_pkg::NUM_W'(MAX_EV), '1);
        fill_table();

        // Directed: time extremes, reposition, wrap, step back
        send_load('0, '0, '0);
        send_load(tet_pkg::IDX_W'(MAX_EV - 1), 32'hFFFF_FFF0, '1);
        send_eval('0, '0);
        send_eval('0, '1);
        send_eval('1, '1);
        // cursor now past the table: step back reads the slot beyond it
        send_eval(32'd5, 32'd10);
        send_eval('1, '0);
        send_eval(stim_times[10], stim_times[20]);
        send_eval(stim_times[25], stim_times[3]);
        send_eval(stim_times[3], stim_times[3]);

        // Empty table drives the cursor to -1
        set_config('0, {$urandom, $urandom});
        send_eval(32'd100, 32'd200);
        send_eval(32'd300, 32'd300);
        send_eval(32'd300, 32'd400);
        // Negative cursor reaches the forward scan
        set_config(tet_pkg::NUM_W'(5), '1);
        send_eval(32'd500, 32'h4000_0000);
        set_config('1, '0);
        send_eval(32'h4000_0000, 32'h0000_0100);
        send_eval(32'h0000_0100, '1);

        // Random phases over several settings
        for (int ph = 0; ph < 6; ph++) begin
            tx_calm = (ph == 2) ? 1'b1 : ($urandom_range(0, 3) == 0);
            rx_calm = (ph == 2) ? 1'b1 : ($urandom_range(0, 3) == 0);
            case (ph)
                0: set_config(tet_pkg::NUM_W'(MAX_EV), '1);
                1: set_config('1, {$urandom, $urandom});
                2: set_config(tet_pkg::NUM_W'(1), {$urandom, $urandom});
                3: set_config(tet_pkg::NUM_W'(17), {$urandom, $urandom});
                4: set_config('0, '0);
                default: set_config(tet_pkg::NUM_W'($urandom_range(0, 63)),
                                    {$urandom, $urandom});
            endcase
            if (ph == 3)
                fill_table();
            if (ph == 3) begin
                // Stall the output while the input keeps coming
                tx_calm    = 1'b1;
                hold_start = 1'b1;
            end
            if (ph == 1) begin
                random_items(6);
                wait_results();
                random_items(6);
            end else begin
                random_items(12);
            end
        end

        // Drain, then a quiet tail to catch stray items
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_results.size() == 0)
            $display("PASS timeline_event_trigger_top");
        else
            $display("FAIL timeline_event_trigger_top");
        $finish;
    end

endmodule
